FILE: hdl/assert_macros.svh
// assertion macros used by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property checked on every rising clock edge outside reset
`define OLS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ols assertion failed");
// property checked on every rising clock edge, reset included
`define OLS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("ols assertion failed");
`else
`define OLS_ASSERT(lbl, clk, rst_n, prop)
`define OLS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: hdl/ols_pkg.sv
// types and constants for the ordered list store
`default_nettype none

package ols_pkg;

    // store geometry
    localparam int DEPTH  = 64;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int VAL_W  = 32;
    localparam int FLD_W  = 7;
    localparam int CMP_W  = ((CNT_W > FLD_W) ? CNT_W : FLD_W) + 1;

    // search tree grouping
    localparam int GRP    = 8;
    localparam int GRP_W  = $clog2(GRP);
    localparam int NGRP   = (DEPTH + GRP - 1) / GRP;

    typedef logic signed [VAL_W-1:0] t_value;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_SEARCH = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_GRP,
        S_FIN
    } t_state;

    // what a cell loads on the next edge
    typedef enum logic [1:0] {
        SEL_HOLD,
        SEL_LOAD,
        SEL_LEFT,
        SEL_RIGHT
    } t_cell_sel;

    typedef struct packed {
        t_cell_sel sel;
        logic      live;
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: hdl/ols_cell.sv
// one storage cell of the list chain with its own equality compare
`default_nettype none

module ols_cell (
    input  wire logic               i_clk,
    input  wire ols_pkg::t_cell_ctl i_ctl,
    input  wire ols_pkg::t_value    i_load,
    input  wire ols_pkg::t_value    i_left,
    input  wire ols_pkg::t_value    i_right,
    input  wire ols_pkg::t_value    i_key,
    output ols_pkg::t_value         o_data,
    output logic                    o_match
);
    import ols_pkg::*;

    t_value r_data;
    t_value n_data;
    logic   r_match;

    // pick the next entry value: hold, new value or a neighbor
    always_comb begin
        case (i_ctl.sel)
            SEL_LOAD:  n_data = i_load;
            SEL_LEFT:  n_data = i_left;
            SEL_RIGHT: n_data = i_right;
            default:   n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_match <= i_ctl.live && (r_data == i_key);
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule

`default_nettype wire

FILE: hdl/ols_find.sv
// registered first-match finder over the cell match flags
`default_nettype none

module ols_find (
    input  wire logic                       i_clk,
    input  wire logic [ols_pkg::DEPTH-1:0]  i_match,
    output logic      [ols_pkg::CNT_W-1:0]  o_found
);
    import ols_pkg::*;

    logic [NGRP*GRP-1:0] w_pad;
    logic                r_grp_hit [NGRP];
    logic [GRP_W-1:0]    r_grp_idx [NGRP];
    logic                n_grp_hit [NGRP];
    logic [GRP_W-1:0]    n_grp_idx [NGRP];

    // pad the flags out to whole groups
    always_comb begin
        w_pad = '0;
        w_pad[DEPTH-1:0] = i_match;
    end

    // first hit inside each group
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp_hit[g] = 1'b0;
            n_grp_idx[g] = '0;
            for (int k = GRP - 1; k >= 0; k--) begin
                if (w_pad[g*GRP + k]) begin
                    n_grp_hit[g] = 1'b1;
                    n_grp_idx[g] = GRP_W'(k);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp_hit <= n_grp_hit;
        r_grp_idx <= n_grp_idx;
    end

    // first group with a hit gives the 1-based position
    always_comb begin
        o_found = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (r_grp_hit[g]) begin
                o_found = CNT_W'(g*GRP + int'(r_grp_idx[g]) + 1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/ordered_list_store.sv
// Ordered list store: positional insert, delete and first-match search.
// Insert, delete and an unused kind are done at the transfer; the result is then registered.
// Search steps through the compare, group find and pick states before its result is registered.
// A result waiting at the output does not block the next transfer; a second stage holds one more.
// Synchronous active-low reset empties the list and clears the handshake; entry data is not reset.
`default_nettype none
`include "assert_macros.svh"

module ordered_list_store (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [1:0]                 i_kind,
    input  wire logic [ols_pkg::FLD_W-1:0]  i_position,
    input  wire ols_pkg::t_value            i_value,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic [1:0]                      o_status,
    output logic [ols_pkg::FLD_W-1:0]       o_found_at,
    output logic [ols_pkg::FLD_W-1:0]       o_length
);
    import ols_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    t_value             r_key;

    logic               r_out_valid;
    t_status            r_out_status;
    logic [FLD_W-1:0]   r_out_found;
    logic [FLD_W-1:0]   r_out_length;
    logic               r_pend_valid;
    t_status            r_pend_status;
    logic [FLD_W-1:0]   r_pend_found;
    logic [FLD_W-1:0]   r_pend_length;

    logic               w_in_acc;
    logic               w_out_free;
    logic [CMP_W-1:0]   w_pos;
    logic [CMP_W-1:0]   w_cnt;
    logic               w_do_ins;
    logic               w_do_del;
    logic               w_res_valid;
    t_status            w_res_status;
    logic [FLD_W-1:0]   w_res_found;
    logic [FLD_W-1:0]   w_res_length;
    logic [CNT_W-1:0]   w_found;

    t_cell_ctl          w_ctl  [DEPTH];
    t_value             w_data [DEPTH];
    logic [DEPTH-1:0]   w_match;

    // input transfer handshake
    assign o_in_stall = (r_state != S_IDLE) || r_pend_valid;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_pos = CMP_W'(i_position);
    assign w_cnt = CMP_W'(r_count);

    // decode the operation and build its result
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        w_do_ins     = 1'b0;
        w_do_del     = 1'b0;
        w_res_valid  = 1'b0;
        w_res_status = ST_OK;
        w_res_found  = '0;
        w_res_length = FLD_W'(r_count);
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    w_res_valid = 1'b1;
                    if (i_kind == KIND_INSERT) begin
                        if (w_pos == '0 || w_pos > w_cnt + 1'b1) begin
                            w_res_status = ST_RANGE;
                        end else if (r_count == CNT_W'(DEPTH)) begin
                            w_res_status = ST_FULL;
                        end else begin
                            w_do_ins = 1'b1;
                            n_count  = r_count + 1'b1;
                        end
                    end else if (i_kind == KIND_DELETE) begin
                        if (w_pos == '0 || w_pos > w_cnt) begin
                            w_res_status = ST_RANGE;
                        end else begin
                            w_do_del = 1'b1;
                            n_count  = r_count - 1'b1;
                        end
                    end else if (i_kind == KIND_SEARCH) begin
                        w_res_valid = 1'b0;
                        n_state     = S_CMP;
                    end else begin
                        w_res_status = ST_RANGE;
                    end
                    w_res_length = FLD_W'(n_count);
                end
            end
            S_CMP: n_state = S_GRP;
            S_GRP: n_state = S_FIN;
            S_FIN: begin
                w_res_valid = 1'b1;
                w_res_found = FLD_W'(w_found);
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // per-cell shift control
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_ctl[i].live = (CMP_W'(i) < w_cnt);
            w_ctl[i].sel  = SEL_HOLD;
            if (w_do_ins) begin
                if (CMP_W'(i + 1) == w_pos) begin
                    w_ctl[i].sel = SEL_LOAD;
                end else if (CMP_W'(i + 1) > w_pos) begin
                    w_ctl[i].sel = SEL_LEFT;
                end
            end else if (w_do_del) begin
                if (CMP_W'(i + 1) >= w_pos) begin
                    w_ctl[i].sel = SEL_RIGHT;
                end
            end
        end
    end

    // chain of cells
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        t_value w_left;
        t_value w_right;
        if (i == 0) begin : g_first
            assign w_left = i_value;
        end else begin : g_mid_l
            assign w_left = w_data[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign w_right = w_data[i];
        end else begin : g_mid_r
            assign w_right = w_data[i+1];
        end
        ols_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[i]),
            .i_load  (i_value),
            .i_left  (w_left),
            .i_right (w_right),
            .i_key   (r_key),
            .o_data  (w_data[i]),
            .o_match (w_match[i])
        );
    end

    ols_find u_find (
        .i_clk   (i_clk),
        .i_match (w_match),
        .o_found (w_found)
    );

    // control state, length and search key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_key <= i_value;
        end
    end

    // output register with one skid stage behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_pend_valid) begin
                r_out_valid  <= 1'b1;
                r_pend_valid <= w_res_valid;
            end else begin
                r_out_valid  <= w_res_valid;
            end
        end else if (w_res_valid) begin
            r_pend_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_pend_valid) begin
                r_out_status  <= r_pend_status;
                r_out_found   <= r_pend_found;
                r_out_length  <= r_pend_length;
                r_pend_status <= w_res_status;
                r_pend_found  <= w_res_found;
                r_pend_length <= w_res_length;
            end else begin
                r_out_status  <= w_res_status;
                r_out_found   <= w_res_found;
                r_out_length  <= w_res_length;
            end
        end else if (w_res_valid) begin
            r_pend_status <= w_res_status;
            r_pend_found  <= w_res_found;
            r_pend_length <= w_res_length;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_found_at  = r_out_found;
    assign o_length    = r_out_length;

    // checks
    `OLS_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH))
    `OLS_ASSERT(a_pend_behind_out, i_clk, i_rst_n, r_pend_valid |-> r_out_valid)
    `OLS_ASSERT(a_count_only_on_transfer, i_clk, i_rst_n, !w_in_acc |=> $stable(r_count))
    `OLS_ASSERT(a_search_steps, i_clk, i_rst_n, (r_state == S_CMP) |=> (r_state == S_GRP))

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// testbench for ordered_list_store: directed and random list operations checked against a model
`default_nettype none

module tb_top;
    import ols_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam t_value     VAL_MIN     = 32'sh8000_0000;
    localparam t_value     VAL_MAX     = 32'sh7FFF_FFFF;
    localparam int         POS_TOP     = (1 << FLD_W) - 1;
    localparam int         SETTLE_CYC  = 12;
    localparam int         MAX_SHOWN   = 10;

    typedef struct packed {
        t_status          status;
        logic [FLD_W-1:0] found_at;
        logic [FLD_W-1:0] length;
    } t_list_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [1:0]          i_kind;
    logic [FLD_W-1:0]    i_position;
    t_value              i_value;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [1:0]          o_status;
    logic [FLD_W-1:0]    o_found_at;
    logic [FLD_W-1:0]    o_length;

    // model of the list contents and the results still owed by the block
    t_value        list_model[$];
    t_list_result  owed_results[$];
    t_list_result  oldest_owed;
    int            mismatch_cnt;
    int            burst_left;
    bit            gaps_on;
    int            stall_mode;
    logic [15:0]   cyc_cnt;

    ordered_list_store u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_found_at  (o_found_at),
        .o_length    (o_length)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // apply one operation to the list model and return what the block must report
    function automatic t_list_result apply_list_op(logic [1:0] kind, logic [FLD_W-1:0] pos,
                                                   t_value val);
        t_list_result r;
        int           n;
        n = list_model.size();
        r.status   = ST_OK;
        r.found_at = '0;
        case (kind)
            KIND_INSERT: begin
                if (pos < 1 || int'(pos) > n + 1) begin
                    r.status = ST_RANGE;
                end else if (n >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    list_model.insert(int'(pos) - 1, val);
                end
            end
            KIND_DELETE: begin
                if (pos < 1 || int'(pos) > n) begin
                    r.status = ST_RANGE;
                end else begin
                    list_model.delete(int'(pos) - 1);
                end
            end
            KIND_SEARCH: begin
                // scan from the back so the first match wins
                for (int i = n - 1; i >= 0; i--) begin
                    if (list_model[i] == val) begin
                        r.found_at = FLD_W'(i + 1);
                    end
                end
            end
            default: begin
                r.status = ST_RANGE;
            end
        endcase
        r.length = FLD_W'(list_model.size());
        return r;
    endfunction

    // send one operation; called and returns at a falling edge
    task automatic send_op(input logic [1:0] kind, input logic [FLD_W-1:0] pos, input t_value val);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on) begin
                gap = $urandom_range(1, 8);
                i_in_valid = 1'b0;
                repeat (gap) begin
                    i_kind     = 2'($urandom);
                    i_position = FLD_W'($urandom);
                    i_value    = t_value'($urandom);
                    @(negedge i_clk);
                end
            end
        end
        burst_left--;
        i_kind     = kind;
        i_position = pos;
        i_value    = val;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        owed_results.push_back(apply_list_op(kind, pos, val));
        @(negedge i_clk);
    endtask

    // hold the sender off until every owed result has come back
    task automatic wait_results_done();
        i_in_valid = 1'b0;
        burst_left = 0;
        while (owed_results.size() != 0) @(negedge i_clk);
    endtask

    // values: a small pool for duplicates, the extremes, or anything
    function automatic t_value pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) return t_value'($signed($urandom_range(0, 15)) - 8);
        if (sel == 4) begin
            case ($urandom_range(0, 3))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return '0;
                default: return -1;
            endcase
        end
        return t_value'($urandom);
    endfunction

    // search mostly for values held in the list
    function automatic t_value pick_search_value();
        if (list_model.size() != 0 && $urandom_range(0, 9) < 7) begin
            return list_model[$urandom_range(0, list_model.size() - 1)];
        end
        return pick_value();
    endfunction

    // insert and delete positions mostly in range, sometimes zero or past the end; other kinds get any
    function automatic logic [FLD_W-1:0] pick_position(logic [1:0] kind);
        int lim;
        lim = (kind == KIND_INSERT) ? list_model.size() + 1 : list_model.size();
        if (kind != KIND_INSERT && kind != KIND_DELETE) return FLD_W'($urandom_range(0, POS_TOP));
        if (lim >= 1 && $urandom_range(0, 99) < 85) return FLD_W'($urandom_range(1, lim));
        if ($urandom_range(0, 2) == 0) return '0;
        return FLD_W'($urandom_range(lim + 1, POS_TOP));
    endfunction

    // random operations with the given mix of kinds, plus an occasional unused kind
    task automatic run_random_ops(input int n_ops, input int ins_w, input int del_w,
                                  input int srch_w);
        int          sel;
        logic [1:0]  kind;
        t_value      val;
        repeat (n_ops) begin
            sel = $urandom_range(0, ins_w + del_w + srch_w);
            if (sel < ins_w) kind = KIND_INSERT;
            else if (sel < ins_w + del_w) kind = KIND_DELETE;
            else if (sel < ins_w + del_w + srch_w) kind = KIND_SEARCH;
            else kind = KIND_UNUSED;
            val = (kind == KIND_SEARCH) ? pick_search_value() : pick_value();
            send_op(kind, pick_position(kind), val);
        end
    endtask

    // operations on an empty list
    task automatic test_empty_store();
        send_op(KIND_SEARCH, 7'd0, '0);
        send_op(KIND_DELETE, 7'd1, '0);
        send_op(KIND_DELETE, 7'd0, '0);
        send_op(KIND_INSERT, 7'd2, 32'sd5);
        send_op(KIND_INSERT, 7'd0, 32'sd5);
        send_op(KIND_UNUSED, 7'd1, 32'sd5);
        send_op(KIND_INSERT, 7'(POS_TOP), -1);
    endtask

    // inserts at the front, the back and the middle with extreme values, and one out of range
    task automatic test_edge_inserts();
        send_op(KIND_INSERT, 7'd1, VAL_MIN);
        send_op(KIND_INSERT, 7'd2, VAL_MAX);
        send_op(KIND_INSERT, 7'd1, '0);
        send_op(KIND_INSERT, 7'd2, -1);
        send_op(KIND_INSERT, 7'd3, -1);
        send_op(KIND_INSERT, 7'd7, 32'sd9);
    endtask

    // hits at both ends, a duplicate, and a miss
    task automatic test_edge_searches();
        send_op(KIND_SEARCH, 7'd0, VAL_MIN);
        send_op(KIND_SEARCH, 7'd0, VAL_MAX);
        send_op(KIND_SEARCH, 7'd0, -1);
        send_op(KIND_SEARCH, 7'(POS_TOP), 32'sd12345);
        send_op(KIND_SEARCH, 7'd3, '0);
    endtask

    // deletes out of range, at the end, the front and the middle
    task automatic test_edge_deletes();
        send_op(KIND_DELETE, 7'd0, '0);
        send_op(KIND_DELETE, 7'd6, '0);
        send_op(KIND_DELETE, 7'd5, '0);
        send_op(KIND_DELETE, 7'd1, '0);
        send_op(KIND_DELETE, 7'd2, '0);
        send_op(KIND_UNUSED, 7'd1, -1);
    endtask

    // grow until full and keep pushing against the full store
    task automatic test_fill_store();
        run_random_ops(300, 8, 1, 2);
    endtask

    // balanced mix of inserts, deletes and searches
    task automatic test_churn();
        run_random_ops(450, 3, 3, 3);
    endtask

    // shrink back toward empty
    task automatic test_empty_out();
        run_random_ops(250, 1, 6, 2);
    endtask

    // back-to-back transfers with no sender gaps
    task automatic test_back_to_back();
        gaps_on = 1'b0;
        burst_left = 0;
        run_random_ops(150, 4, 3, 3);
        gaps_on = 1'b1;
    endtask

    // receiver stall pattern, picks a new mode whenever the low six bits of the cycle counter are zero
    always @(negedge i_clk) begin
        cyc_cnt <= cyc_cnt + 16'd1;
        if (cyc_cnt[5:0] == 6'd0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: i_out_stall = 1'b0;
            1: i_out_stall = ($urandom_range(0, 2) == 0);
            2: i_out_stall = (cyc_cnt[2:0] < 3'd3);
            default: i_out_stall = (cyc_cnt[3:0] < 4'd10);
        endcase
    end

    task automatic note_mismatch(input string what, input t_list_result want);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_SHOWN) begin
            $display("%s: expected status %0d found_at %0d length %0d, got %0d %0d %0d",
                     what, want.status, want.found_at, want.length,
                     o_status, o_found_at, o_length);
        end
    endtask

    // check each result transfer against the oldest owed result
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (owed_results.size() == 0) begin
                note_mismatch("unexpected result", '0);
            end else begin
                oldest_owed = owed_results.pop_front();
                if (o_status !== oldest_owed.status || o_found_at !== oldest_owed.found_at ||
                    o_length !== oldest_owed.length) begin
                    note_mismatch("result mismatch", oldest_owed);
                end
            end
        end
    end

    // run limit
    initial begin
        #5_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    // test sequence
    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_kind       = KIND_INSERT;
        i_position   = '0;
        i_value      = '0;
        i_out_stall  = 1'b0;
        cyc_cnt      = '0;
        stall_mode   = 0;
        mismatch_cnt = 0;
        burst_left   = 0;
        gaps_on      = 1'b1;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_store();
        test_edge_inserts();
        test_edge_searches();
        test_edge_deletes();
        wait_results_done();
        test_fill_store();
        wait_results_done();
        test_churn();
        test_back_to_back();
        wait_results_done();
        test_empty_out();

        wait_results_done();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (mismatch_cnt == 0 && owed_results.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
